// File: sv/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

   localparam int OP_W      = 2;
   localparam int IDX_W     = 12;
   localparam int GRANT_W   = 11;
   localparam int CNT_W     = 12;
   localparam int STATUS_W  = 2;
   localparam int WORD_W    = 64;
   localparam int BITPOS_W  = 6;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [BITPOS_W-1:0] bitpos_type;

   localparam op_type OP_ALLOCATE = 2'd0;
   localparam op_type OP_REQUEST  = 2'd1;
   localparam op_type OP_RELEASE  = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_TAKEN = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

endpackage

// File: sv/bitmap_block_allocator_unit.sv
`timescale 1ns / 1ps

// Block allocator over a one-bit-per-block map held in a synchronous memory
// of 64-bit words. A transaction on the req_ channel carries an operation and
// a block index: allocate the lowest free block outside the reserved range,
// request one named block, or release one named block. Each transaction
// produces exactly one rsp_ transaction with a status, the granted block and
// the used and free counts after the operation.
// Allocate reads the map one word per cycle, bounded by the single read port,
// and stops at the first word with a free block or after the last word.
// Request and release read the word, then test the bit and write back any change.
// One transaction is worked on at a time; the next is taken once the current
// result is in the output register, even while the receiver has not taken it.
// After reset the block sweeps the memory once, one word a cycle, writing
// the reset image with the reserved blocks marked; req_ready stays low
// during that sweep. When the receiver stalls, the result waits in the output
// register and a finished result behind it holds the block until the register
// frees.
module bitmap_block_allocator_unit #(
   parameter int BLOCK_COUNT    = 2048,
   parameter int RESERVED_BASE  = 1022,
   parameter int RESERVED_COUNT = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bba_pkg::OP_W-1:0]         req_op,
   input  logic [bba_pkg::IDX_W-1:0]        req_block_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bba_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bba_pkg::GRANT_W-1:0]      rsp_granted_index,
   output logic [bba_pkg::CNT_W-1:0]        rsp_used_count,
   output logic [bba_pkg::CNT_W-1:0]        rsp_free_count
);

   localparam int MAP_WORDS  = (BLOCK_COUNT + 63) / 64;
   localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int UW         = $clog2(BLOCK_COUNT + 1);
   localparam int RESET_USED = (RESERVED_BASE >= BLOCK_COUNT) ? 0 :
                               ((RESERVED_BASE + RESERVED_COUNT > BLOCK_COUNT) ?
                                (BLOCK_COUNT - RESERVED_BASE) : RESERVED_COUNT);
   localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_RMW   = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   function automatic bba_pkg::word_type reserved_word(input logic [AW-1:0] w);
      bba_pkg::word_type r;
      int unsigned       i;
      r = '0;
      for (int b = 0; b < bba_pkg::WORD_W; b++) begin
         i = (32'(w) << 6) + 32'(b);
         r[b] = (i >= 32'(RESERVED_BASE)) &&
                (i < 32'(RESERVED_BASE) + 32'(RESERVED_COUNT)) &&
                (i < 32'(BLOCK_COUNT));
      end
      return r;
   endfunction

   function automatic bba_pkg::word_type alloc_mask(input logic [AW-1:0] w);
      bba_pkg::word_type r;
      int unsigned       i;
      r = '0;
      for (int b = 0; b < bba_pkg::WORD_W; b++) begin
         i = (32'(w) << 6) + 32'(b);
         r[b] = (i < 32'(BLOCK_COUNT)) &&
                !((i >= 32'(RESERVED_BASE)) &&
                  (i < 32'(RESERVED_BASE) + 32'(RESERVED_COUNT)));
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] word_of(input logic [bba_pkg::IDX_W-1:0] i);
      logic [31:0] t;
      t = 32'(i) >> 6;
      return AW'(t);
   endfunction

   bba_pkg::word_type mem [MAP_WORDS];
   bba_pkg::word_type mem_rdata_ff;
   logic [AW-1:0]     mem_raddr;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   bba_pkg::word_type mem_wdata;

   logic [2:0]                    state_ff, state_in;
   bba_pkg::op_type               op_ff, op_in;
   logic [bba_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [AW-1:0]                 clr_addr_ff, clr_addr_in;
   logic [AW-1:0]                 scan_addr_ff, scan_addr_in;
   logic                          issue_ff, issue_in;
   logic [AW-1:0]                 chk_addr_ff, chk_addr_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic [UW-1:0]                 used_ff, used_in;
   bba_pkg::status_type           res_status_ff, res_status_in;
   logic [bba_pkg::GRANT_W-1:0]   res_grant_ff, res_grant_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bba_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [bba_pkg::GRANT_W-1:0]   rsp_grant_ff, rsp_grant_in;
   logic [bba_pkg::CNT_W-1:0]     rsp_used_ff, rsp_used_in;
   logic [bba_pkg::CNT_W-1:0]     rsp_free_ff, rsp_free_in;

   bba_pkg::word_type  avail;
   logic               hit;
   bba_pkg::bitpos_type hit_pos;
   bba_pkg::bitpos_type sel_pos;
   logic               sel_bit;
   logic               in_range;
   logic               req_fire;
   logic               rsp_free_slot;
   logic [31:0]        free_calc;

   assign avail   = ~mem_rdata_ff & alloc_mask(chk_addr_ff);
   assign hit     = |avail;
   assign sel_pos = idx_ff[bba_pkg::BITPOS_W-1:0];
   assign sel_bit = mem_rdata_ff[sel_pos];
   assign in_range = 32'(idx_ff) < 32'(BLOCK_COUNT);

   always_comb begin
      hit_pos = '0;
      for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            hit_pos = bba_pkg::BITPOS_W'(b);
         end
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign rsp_free_slot = !rsp_valid_ff || rsp_ready;
   assign free_calc     = 32'(BLOCK_COUNT) - 32'(used_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      clr_addr_in   = clr_addr_ff;
      scan_addr_in  = scan_addr_ff;
      issue_in      = issue_ff;
      chk_addr_in   = chk_addr_ff;
      chk_valid_in  = 1'b0;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;
      mem_raddr     = word_of(req_block_index);
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[bba_pkg::IDX_W-1:0] == '0 ? '0 : word_of(idx_ff);
      mem_wdata     = mem_rdata_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = reserved_word(clr_addr_ff);
            clr_addr_in = AW'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_op;
               idx_in        = req_block_index;
               res_status_in = bba_pkg::ST_OK;
               res_grant_in  = '0;
               if (req_op == bba_pkg::OP_ALLOCATE) begin
                  scan_addr_in = '0;
                  issue_in     = 1'b1;
                  state_in     = S_SCAN;
               end else if (req_op == bba_pkg::OP_REQUEST ||
                            req_op == bba_pkg::OP_RELEASE) begin
                  state_in = S_RMW;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            mem_raddr = scan_addr_ff;
            if (issue_ff) begin
               scan_addr_in = AW'(scan_addr_ff + 1'b1);
               chk_addr_in  = scan_addr_ff;
               chk_valid_in = 1'b1;
               if (scan_addr_ff == LAST_WORD) begin
                  issue_in = 1'b0;
               end
            end
            if (chk_valid_ff) begin
               if (hit) begin
                  mem_we        = 1'b1;
                  mem_waddr     = chk_addr_ff;
                  mem_wdata     = mem_rdata_ff | (bba_pkg::WORD_W'(1) << hit_pos);
                  used_in       = UW'(used_ff + 1'b1);
                  res_status_in = bba_pkg::ST_OK;
                  res_grant_in  = bba_pkg::GRANT_W'({chk_addr_ff, hit_pos});
                  issue_in      = 1'b0;
                  chk_valid_in  = 1'b0;
                  state_in      = S_RESP;
               end else if (chk_addr_ff == LAST_WORD) begin
                  res_status_in = bba_pkg::ST_FULL;
                  issue_in      = 1'b0;
                  chk_valid_in  = 1'b0;
                  state_in      = S_RESP;
               end
            end
         end
         S_RMW: begin
            mem_waddr = word_of(idx_ff);
            state_in  = S_RESP;
            if (!in_range) begin
               res_status_in = bba_pkg::ST_RANGE;
            end else if (op_ff == bba_pkg::OP_REQUEST) begin
               if (sel_bit) begin
                  res_status_in = bba_pkg::ST_TAKEN;
               end else begin
                  mem_we       = 1'b1;
                  mem_wdata    = mem_rdata_ff | (bba_pkg::WORD_W'(1) << sel_pos);
                  used_in      = UW'(used_ff + 1'b1);
                  res_grant_in = bba_pkg::GRANT_W'(idx_ff);
               end
            end else begin
               if (sel_bit) begin
                  mem_we    = 1'b1;
                  mem_wdata = mem_rdata_ff & ~(bba_pkg::WORD_W'(1) << sel_pos);
                  used_in   = UW'(used_ff - 1'b1);
               end
            end
         end
         S_RESP: begin
            if (rsp_free_slot) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_grant_in  = res_grant_ff;
               rsp_used_in   = bba_pkg::CNT_W'(used_ff);
               rsp_free_in   = bba_pkg::CNT_W'(free_calc);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         issue_ff     <= 1'b0;
         chk_valid_ff <= 1'b0;
         used_ff      <= UW'(RESET_USED);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      scan_addr_ff  <= scan_addr_in;
      chk_addr_ff   <= chk_addr_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_grant_ff;
   assign rsp_used_count    = rsp_used_ff;
   assign rsp_free_count    = rsp_free_ff;

`ifndef SYNTHESIS
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) <= 32'(BLOCK_COUNT))
      else $error("used count exceeds the number of blocks");

   a_update_then_resp: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff != S_CLEAR) |=> (state_ff == S_RESP))
      else $error("map update not followed by a result");

   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bba_pkg::ST_OK) |-> (rsp_granted_index == '0))
      else $error("granted index set on a failed transaction");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("transaction accepted during the clearing sweep");
`endif

endmodule

// File: tb/bitmap_block_allocator_unit_tb.sv
`timescale 1ns / 1ps

module bitmap_block_allocator_unit_tb;

   localparam int BLOCK_COUNT    = 2048;
   localparam int RESERVED_BASE  = 1022;
   localparam int RESERVED_COUNT = 4;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 500;
   localparam bba_pkg::op_type OP_UNUSED = 2'd3;

   typedef struct {
      bba_pkg::op_type           op;
      logic [bba_pkg::IDX_W-1:0] idx;
   } req_item_type;

   typedef struct packed {
      bba_pkg::status_type         status;
      logic [bba_pkg::GRANT_W-1:0] granted;
      logic [bba_pkg::CNT_W-1:0]   used;
      logic [bba_pkg::CNT_W-1:0]   free;
   } alloc_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [bba_pkg::OP_W-1:0]     req_op = '0;
   logic [bba_pkg::IDX_W-1:0]    req_block_index = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [bba_pkg::STATUS_W-1:0] rsp_status;
   logic [bba_pkg::GRANT_W-1:0]  rsp_granted_index;
   logic [bba_pkg::CNT_W-1:0]    rsp_used_count;
   logic [bba_pkg::CNT_W-1:0]    rsp_free_count;

   req_item_type     pending_items[$];
   alloc_result_type predicted_outcomes[$];

   bit block_taken [BLOCK_COUNT];
   int blocks_in_use;

   int mismatch_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   bitmap_block_allocator_unit #(
      .BLOCK_COUNT(BLOCK_COUNT),
      .RESERVED_BASE(RESERVED_BASE),
      .RESERVED_COUNT(RESERVED_COUNT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_block_index(req_block_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_granted_index(rsp_granted_index),
      .rsp_used_count(rsp_used_count),
      .rsp_free_count(rsp_free_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_reserved_block(int idx);
      return idx >= RESERVED_BASE && idx < RESERVED_BASE + RESERVED_COUNT;
   endfunction

   task automatic reset_block_model();
      int i;
      for (i = 0; i < BLOCK_COUNT; i++) block_taken[i] = 1'b0;
      blocks_in_use = 0;
      for (i = RESERVED_BASE; i < RESERVED_BASE + RESERVED_COUNT; i++) begin
         if (i < BLOCK_COUNT) begin
            block_taken[i] = 1'b1;
            blocks_in_use++;
         end
      end
   endtask

   function automatic alloc_result_type apply_block_op(bba_pkg::op_type op,
                                                       logic [bba_pkg::IDX_W-1:0] idx);
      alloc_result_type r;
      int i;
      int n;
      r.status  = bba_pkg::ST_OK;
      r.granted = '0;
      n = int'(idx);
      case (op)
         bba_pkg::OP_ALLOCATE: begin
            r.status = bba_pkg::ST_FULL;
            for (i = 0; i < BLOCK_COUNT; i++) begin
               if (!is_reserved_block(i) && !block_taken[i]) begin
                  block_taken[i] = 1'b1;
                  blocks_in_use++;
                  r.granted = i[bba_pkg::GRANT_W-1:0];
                  r.status  = bba_pkg::ST_OK;
                  break;
               end
            end
         end
         bba_pkg::OP_REQUEST: begin
            if (n >= BLOCK_COUNT) begin
               r.status = bba_pkg::ST_RANGE;
            end else if (block_taken[n]) begin
               r.status = bba_pkg::ST_TAKEN;
            end else begin
               block_taken[n] = 1'b1;
               blocks_in_use++;
               r.granted = idx[bba_pkg::GRANT_W-1:0];
            end
         end
         bba_pkg::OP_RELEASE: begin
            if (n >= BLOCK_COUNT) begin
               r.status = bba_pkg::ST_RANGE;
            end else if (block_taken[n]) begin
               block_taken[n] = 1'b0;
               blocks_in_use--;
            end
         end
         default: begin
         end
      endcase
      r.used = blocks_in_use[bba_pkg::CNT_W-1:0];
      r.free = bba_pkg::CNT_W'(BLOCK_COUNT - blocks_in_use);
      return r;
   endfunction

   function automatic int draw_gap(bit calm);
      return calm ? 0 : int'($urandom_range(0, 10));
   endfunction

   function automatic logic [bba_pkg::IDX_W-1:0] pick_index();
      case ($urandom_range(0, 5))
         0: return bba_pkg::IDX_W'($urandom_range(0, 63));
         1: return bba_pkg::IDX_W'($urandom_range(RESERVED_BASE - 6, RESERVED_BASE + 9));
         2: return bba_pkg::IDX_W'($urandom_range(BLOCK_COUNT - 8, BLOCK_COUNT + 7));
         3: return bba_pkg::IDX_W'($urandom_range(0, 4095));
         4: return bba_pkg::IDX_W'($urandom_range(0, 511));
         default: return bba_pkg::IDX_W'($urandom_range(0, BLOCK_COUNT - 1));
      endcase
   endfunction

   task automatic push_item(bba_pkg::op_type op, int idx);
      req_item_type it;
      it.op  = op;
      it.idx = idx[bba_pkg::IDX_W-1:0];
      pending_items.push_back(it);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("mismatch on result %0d: %s got %0d want %0d", result_count, what, got, want);
   endtask

   always @(posedge clock) begin
      req_item_type nxt;
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            predicted_outcomes.push_back(apply_block_op(req_op, req_block_index));
            accepted_count <= accepted_count + 1;
            send_gap = draw_gap(((accepted_count / 200) % 4) == 3);
         end
         if (!req_valid || fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               nxt = pending_items.pop_front();
               req_valid <= 1'b1;
               req_op <= nxt.op;
               req_block_index <= nxt.idx;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && result_count >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_outcomes.size() == 0) begin
               report_mismatch("unexpected transaction, status", int'(rsp_status), 0);
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_granted_index !== want.granted)
                  report_mismatch("granted_index", int'(rsp_granted_index),
                                  int'(want.granted));
               if (rsp_used_count !== want.used)
                  report_mismatch("used_count", int'(rsp_used_count), int'(want.used));
               if (rsp_free_count !== want.free)
                  report_mismatch("free_count", int'(rsp_free_count), int'(want.free));
            end
            result_count <= result_count + 1;
            recv_gap = draw_gap(((result_count / 200) % 4) == 1);
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
         rsp_ready <= (recv_gap == 0) && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int k;
      int r;
      reset_block_model();

      // Directed: range edges, reserved blocks, taken and free cases, unused code.
      push_item(bba_pkg::OP_ALLOCATE, 0);
      push_item(bba_pkg::OP_REQUEST, 0);
      push_item(bba_pkg::OP_REQUEST, BLOCK_COUNT - 1);
      push_item(bba_pkg::OP_REQUEST, BLOCK_COUNT);
      push_item(bba_pkg::OP_REQUEST, 4095);
      push_item(bba_pkg::OP_RELEASE, 4095);
      push_item(bba_pkg::OP_RELEASE, BLOCK_COUNT);
      push_item(bba_pkg::OP_RELEASE, 5);
      push_item(bba_pkg::OP_RELEASE, 0);
      push_item(bba_pkg::OP_RELEASE, RESERVED_BASE);
      push_item(bba_pkg::OP_REQUEST, RESERVED_BASE);
      push_item(bba_pkg::OP_RELEASE, RESERVED_BASE + 1);
      push_item(bba_pkg::OP_ALLOCATE, 4095);
      push_item(bba_pkg::OP_REQUEST, RESERVED_BASE + 1);
      push_item(bba_pkg::OP_REQUEST, RESERVED_BASE - 1);
      push_item(bba_pkg::OP_REQUEST, RESERVED_BASE + RESERVED_COUNT);
      push_item(bba_pkg::OP_RELEASE, RESERVED_BASE + 2);
      push_item(OP_UNUSED, 4095);
      push_item(OP_UNUSED, 0);
      push_item(bba_pkg::OP_REQUEST, RESERVED_BASE + 2);
      push_item(bba_pkg::OP_RELEASE, BLOCK_COUNT - 1);
      push_item(bba_pkg::OP_ALLOCATE, 2730);
      push_item(bba_pkg::OP_RELEASE, 0);

      // Mixed traffic over a partly filled map.
      for (k = 0; k < 300; k++) begin
         r = $urandom_range(0, 99);
         if (r < 40) push_item(bba_pkg::OP_ALLOCATE, $urandom_range(0, 4095));
         else if (r < 65) push_item(bba_pkg::OP_REQUEST, pick_index());
         else if (r < 95) push_item(bba_pkg::OP_RELEASE, pick_index());
         else push_item(OP_UNUSED, $urandom_range(0, 4095));
      end

      // Mostly allocations, so the map keeps filling.
      for (k = 0; k < 800; k++) begin
         if ($urandom_range(0, 9) == 0) push_item(bba_pkg::OP_REQUEST, pick_index());
         else push_item(bba_pkg::OP_ALLOCATE, $urandom_range(0, 4095));
      end

      // Churn over the partly filled map.
      for (k = 0; k < 130; k++) begin
         r = $urandom_range(0, 99);
         if (r < 45) push_item(bba_pkg::OP_RELEASE, pick_index());
         else if (r < 80) push_item(bba_pkg::OP_ALLOCATE, $urandom_range(0, 4095));
         else push_item(bba_pkg::OP_REQUEST, pick_index());
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (pending_items.size() > 0 || req_valid) @(negedge clock);
      while (predicted_outcomes.size() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
sv/bba_pkg.sv
sv/bitmap_block_allocator_unit.sv
tb/bitmap_block_allocator_unit_tb.sv
